// File: hdl/mips_cop0_system_control_top_defines.svh
// assertion macros shared by the rtl
`ifndef MIPS_COP0_SYSTEM_CONTROL_TOP_DEFINES_SVH
`define MIPS_COP0_SYSTEM_CONTROL_TOP_DEFINES_SVH

// plain property under clock and active-low reset
`define MC0_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MC0_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/mc0_pkg.sv
`timescale 1ns / 1ps

package mc0_pkg;

  localparam int unsigned InstrW = 26;
  localparam int unsigned WordW  = 32;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned NumDbg   = 9;
  localparam int unsigned DbgIdxW  = 4;

  // control register numbers
  localparam logic [4:0] CP_STATUS   = 5'd12;
  localparam logic [4:0] CP_EPC      = 5'd14;
  localparam logic [4:0] CP_ERROREPC = 5'd30;

  // status bit positions
  localparam int unsigned ST_EXL = 1;
  localparam int unsigned ST_ERL = 2;
  localparam int unsigned ST_KSU_LO = 3;
  localparam int unsigned ST_KSU_HI = 4;
  localparam int unsigned ST_EIE = 16;
  localparam int unsigned ST_EDI = 17;

  // rs field codes
  localparam logic [4:0] RS_MF = 5'd0;
  localparam logic [4:0] RS_MT = 5'd4;
  localparam logic [4:0] RS_BC = 5'd8;
  localparam logic [4:0] RS_CO = 5'd16;

  // funct codes of the tlb / eret / ei / di group
  localparam logic [5:0] FN_TLBR  = 6'h01;
  localparam logic [5:0] FN_TLBWI = 6'h02;
  localparam logic [5:0] FN_TLBWR = 6'h06;
  localparam logic [5:0] FN_ERET  = 6'h18;
  localparam logic [5:0] FN_EI    = 6'h38;
  localparam logic [5:0] FN_DI    = 6'h39;

  // debug / perf selectors on the low half of the instruction
  localparam logic [15:0] SEL_IAB  = 16'hc002;
  localparam logic [15:0] SEL_IABM = 16'hc003;
  localparam logic [15:0] SEL_DAB  = 16'hc004;
  localparam logic [15:0] SEL_DABM = 16'hc005;
  localparam logic [15:0] SEL_DVB  = 16'hc006;
  localparam logic [15:0] SEL_DVBM = 16'hc007;
  localparam logic [15:0] SEL_PCR0 = 16'hc801;
  localparam logic [15:0] SEL_PCR1 = 16'hc803;
  localparam logic [15:0] SEL_PCCR = 16'hc800;

  typedef struct packed {
    logic               hit;
    logic [DbgIdxW-1:0] idx;
  } dbg_sel_t;

  typedef struct packed {
    logic              gpr_write;
    logic [4:0]        gpr_index;
    logic [WordW-1:0]  gpr_value;
    logic              pc_load;
    logic [WordW-1:0]  new_pc;
    logic              nullify_slot;
    logic              invalid_op;
  } result_t;

  function automatic dbg_sel_t dbg_select(input logic [15:0] sel);
    dbg_sel_t r;
    r.hit = 1'b1;
    r.idx = '0;
    unique case (sel)
      SEL_IAB:  r.idx = 4'd0;
      SEL_IABM: r.idx = 4'd1;
      SEL_DAB:  r.idx = 4'd2;
      SEL_DABM: r.idx = 4'd3;
      SEL_DVB:  r.idx = 4'd4;
      SEL_DVBM: r.idx = 4'd5;
      SEL_PCR0: r.idx = 4'd6;
      SEL_PCR1: r.idx = 4'd7;
      SEL_PCCR: r.idx = 4'd8;
      default:  r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // ei / di take effect only in kernel-like conditions
  function automatic logic eie_writable(input logic [WordW-1:0] st);
    return st[ST_EDI] | st[ST_EXL] | st[ST_ERL] | (st[ST_KSU_HI:ST_KSU_LO] == 2'b00);
  endfunction

endpackage

// File: hdl/mips_cop0_system_control_top.sv
`timescale 1ns / 1ps
// channel   dir  fields (tdata, lowest bit up)
// s_axis    in   instr_bits[25:0], rt_value[57:26], zero pad [63:58]
// m_axis    out  gpr_write[0], gpr_index[5:1], gpr_value[37:6], pc_load[38],
//                new_pc[70:39], nullify_slot[71], invalid_op[72], zero pad [79:73]
//
// one request per cycle sustained while the receiver is ready
// the request is held in an input register; decode, register file read and
// state update happen in one pass into the result register
// the result register and input register form a two-deep pipe, so a stalled
// result still lets one more request in
// rst_ni clears all control and debug/perf registers and both valid flags

`include "mips_cop0_system_control_top_defines.svh"

module mips_cop0_system_control_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mc0_pkg::InDataW-1:0]   s_axis_tdata,   // instr_bits, rt_value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mc0_pkg::OutDataW-1:0]  m_axis_tdata    // gpr_write, gpr_index,
                                                        // gpr_value, pc_load, new_pc,
                                                        // nullify_slot, invalid_op
);

  // input register
  logic                           in_valid_q;
  logic [mc0_pkg::InstrW-1:0]     instr_q;
  logic [mc0_pkg::WordW-1:0]      rtv_q;

  // result register
  logic                           out_valid_q;
  mc0_pkg::result_t               res_q, res_d;

  // architectural state
  logic [mc0_pkg::WordW-1:0] ctrl_q [32];
  logic [mc0_pkg::WordW-1:0] dbg_q  [mc0_pkg::NumDbg];

  logic advance;
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  // decode fields
  logic [4:0]  rs, rt, rd;
  logic [5:0]  funct;
  logic [mc0_pkg::WordW-1:0] status;
  mc0_pkg::dbg_sel_t dsel;

  assign rs     = instr_q[25:21];
  assign rt     = instr_q[20:16];
  assign rd     = instr_q[15:11];
  assign funct  = instr_q[5:0];
  assign status = ctrl_q[mc0_pkg::CP_STATUS];
  assign dsel   = mc0_pkg::dbg_select(instr_q[15:0]);

  // write-back controls
  logic                       ctrl_we, dbg_we, status_we;
  logic [mc0_pkg::WordW-1:0]  status_d;
  logic                       is_eret;

  always_comb begin
    res_d     = '0;
    ctrl_we   = 1'b0;
    dbg_we    = 1'b0;
    status_we = 1'b0;
    status_d  = status;
    is_eret   = 1'b0;
    unique case (rs)
      mc0_pkg::RS_MF: begin
        res_d.gpr_write = 1'b1;
        res_d.gpr_index = rt;
        res_d.gpr_value = dsel.hit ? dbg_q[dsel.idx] : ctrl_q[rd];
      end
      mc0_pkg::RS_MT: begin
        // move-to: either a debug/perf register or control register rd
        dbg_we  = dsel.hit;
        ctrl_we = ~dsel.hit;
      end
      mc0_pkg::RS_BC: begin
        // bc0f/bc0t pass, likely forms nullify the slot, others invalid
        res_d.nullify_slot = (rt == 5'd2) | (rt == 5'd3);
        res_d.invalid_op   = (rt > 5'd3);
      end
      mc0_pkg::RS_CO: begin
        unique case (funct)
          mc0_pkg::FN_TLBR, mc0_pkg::FN_TLBWI, mc0_pkg::FN_TLBWR: ;
          mc0_pkg::FN_ERET: begin
            is_eret       = 1'b1;
            res_d.pc_load = 1'b1;
            status_we     = 1'b1;
            if (status[mc0_pkg::ST_ERL]) begin
              res_d.new_pc = ctrl_q[mc0_pkg::CP_ERROREPC];
              status_d[mc0_pkg::ST_ERL] = 1'b0;
            end else begin
              res_d.new_pc = ctrl_q[mc0_pkg::CP_EPC];
              status_d[mc0_pkg::ST_EXL] = 1'b0;
            end
          end
          mc0_pkg::FN_EI: begin
            status_we = mc0_pkg::eie_writable(status);
            status_d[mc0_pkg::ST_EIE] = 1'b1;
          end
          mc0_pkg::FN_DI: begin
            status_we = mc0_pkg::eie_writable(status);
            status_d[mc0_pkg::ST_EIE] = 1'b0;
          end
          default: res_d.invalid_op = 1'b1;
        endcase
      end
      default: res_d.invalid_op = 1'b1;
    endcase
  end

  // input register takes a request whenever it is empty or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      instr_q <= s_axis_tdata[mc0_pkg::InstrW-1:0];
      rtv_q   <= s_axis_tdata[mc0_pkg::InstrW +: mc0_pkg::WordW];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // state update happens as the request leaves the input register, so the
  // next request always sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        ctrl_q[i] <= '0;
      end
      for (int j = 0; j < mc0_pkg::NumDbg; j++) begin
        dbg_q[j] <= '0;
      end
    end else if (advance) begin
      if (ctrl_we) begin
        ctrl_q[rd] <= rtv_q;
      end
      if (dbg_we) begin
        dbg_q[dsel.idx] <= rtv_q;
      end
      if (status_we) begin
        ctrl_q[mc0_pkg::CP_STATUS] <= status_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, res_q.invalid_op, res_q.nullify_slot, res_q.new_pc,
                          res_q.pc_load, res_q.gpr_value, res_q.gpr_index,
                          res_q.gpr_write};

  // assertions
  `MC0_ASSERT_NEXT(a_adv_fills_out, clk_i, rst_ni, advance, out_valid_q,
                   "result register empty after advance")
  `MC0_ASSERT(a_flags_excl, clk_i, rst_ni,
              !out_valid_q || $onehot0({res_q.gpr_write, res_q.pc_load,
                                        res_q.nullify_slot, res_q.invalid_op}),
              "more than one result kind set")
  `MC0_ASSERT(a_no_write_zero, clk_i, rst_ni,
              !out_valid_q || res_q.gpr_write ||
              (res_q.gpr_index == 5'd0 && res_q.gpr_value == '0),
              "gpr fields set without gpr_write")
  `MC0_ASSERT_NEXT(a_eret_erl, clk_i, rst_ni,
                   advance && is_eret && status[mc0_pkg::ST_ERL],
                   !ctrl_q[mc0_pkg::CP_STATUS][mc0_pkg::ST_ERL],
                   "eret left erl set")
  `MC0_ASSERT(a_stall_full, clk_i, rst_ni, s_axis_tready || (in_valid_q && out_valid_q),
              "input stalled while pipe not full")

endmodule

// File: dv/tb_mips_cop0_system_control_top.sv
`timescale 1ns / 1ps

module tb_mips_cop0_system_control_top;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned MaxShown  = 40;
  localparam int unsigned NumRandom = 1500;

  // branch condition codes carried in the rt field
  localparam logic [4:0] BC_F  = 5'd0;
  localparam logic [4:0] BC_T  = 5'd1;
  localparam logic [4:0] BC_FL = 5'd2;
  localparam logic [4:0] BC_TL = 5'd3;

  // encodings the block must reject
  localparam logic [5:0] FN_TLBP = 6'h08;
  localparam logic [5:0] FN_BAD  = 6'h3f;
  localparam logic [4:0] RS_BAD  = 5'd31;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic [mc0_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                         m_axis_tready = 1'b0;
  logic                         s_axis_tready;
  logic                         m_axis_tvalid;
  logic [mc0_pkg::OutDataW-1:0] m_axis_tdata;

  // shadow copy of the coprocessor register files
  logic [mc0_pkg::WordW-1:0] cp0_ctl [32]              = '{default: '0};
  logic [mc0_pkg::WordW-1:0] cp0_dbg [mc0_pkg::NumDbg] = '{default: '0};

  mc0_pkg::result_t cop0_results_q [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned rx_hold_len = 0;
  bit          tx_gaps_on  = 1'b1;
  bit          rx_gaps_on  = 1'b1;

  mips_cop0_system_control_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [25:0] cop0_word(input logic [4:0] rs, input logic [4:0] rt,
                                            input logic [4:0] rd, input logic [10:0] tail);
    return {rs, rt, rd, tail};
  endfunction

  function automatic logic [15:0] dbg_sel_of(input int unsigned n);
    case (n)
      0: return mc0_pkg::SEL_IAB;
      1: return mc0_pkg::SEL_IABM;
      2: return mc0_pkg::SEL_DAB;
      3: return mc0_pkg::SEL_DABM;
      4: return mc0_pkg::SEL_DVB;
      5: return mc0_pkg::SEL_DVBM;
      6: return mc0_pkg::SEL_PCR0;
      7: return mc0_pkg::SEL_PCR1;
      default: return mc0_pkg::SEL_PCCR;
    endcase
  endfunction

  // debug bank slot hit by the low half, or -1 for the control file
  function automatic int dbg_slot(input logic [15:0] tail);
    for (int n = 0; n < mc0_pkg::NumDbg; n++)
      if (dbg_sel_of(n) == tail) return n;
    return -1;
  endfunction

  // executes one instruction on the shadow state and returns its result
  function automatic mc0_pkg::result_t cop0_execute(input logic [25:0] instr,
                                                    input logic [31:0] rtv);
    mc0_pkg::result_t r;
    logic [31:0]      st;
    int               slot;
    r    = '0;
    st   = cp0_ctl[mc0_pkg::CP_STATUS];
    slot = dbg_slot(instr[15:0]);
    case (instr[25:21])
      mc0_pkg::RS_MF: begin
        r.gpr_write = 1'b1;
        r.gpr_index = instr[20:16];
        r.gpr_value = (slot >= 0) ? cp0_dbg[slot] : cp0_ctl[instr[15:11]];
      end
      mc0_pkg::RS_MT: begin
        if (slot >= 0) cp0_dbg[slot] = rtv;
        else cp0_ctl[instr[15:11]] = rtv;
      end
      mc0_pkg::RS_BC: begin
        if (instr[20:16] == BC_FL || instr[20:16] == BC_TL) r.nullify_slot = 1'b1;
        else if (instr[20:16] != BC_F && instr[20:16] != BC_T) r.invalid_op = 1'b1;
      end
      mc0_pkg::RS_CO: begin
        case (instr[5:0])
          mc0_pkg::FN_TLBR, mc0_pkg::FN_TLBWI, mc0_pkg::FN_TLBWR: begin
          end
          mc0_pkg::FN_ERET: begin
            r.pc_load = 1'b1;
            if (st[mc0_pkg::ST_ERL]) begin
              r.new_pc            = cp0_ctl[mc0_pkg::CP_ERROREPC];
              st[mc0_pkg::ST_ERL] = 1'b0;
            end else begin
              r.new_pc            = cp0_ctl[mc0_pkg::CP_EPC];
              st[mc0_pkg::ST_EXL] = 1'b0;
            end
            cp0_ctl[mc0_pkg::CP_STATUS] = st;
          end
          mc0_pkg::FN_EI, mc0_pkg::FN_DI: begin
            // interrupt enable only moves in kernel mode or with a flag up
            if (st[mc0_pkg::ST_EDI] || st[mc0_pkg::ST_EXL] || st[mc0_pkg::ST_ERL] ||
                st[mc0_pkg::ST_KSU_HI:mc0_pkg::ST_KSU_LO] == 2'b00) begin
              st[mc0_pkg::ST_EIE]         = (instr[5:0] == mc0_pkg::FN_EI);
              cp0_ctl[mc0_pkg::CP_STATUS] = st;
            end
          end
          default: r.invalid_op = 1'b1;
        endcase
      end
      default: r.invalid_op = 1'b1;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MaxShown) $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // offers one request and records its expected result once it is taken
  task automatic send_instr(input logic [25:0] instr, input logic [31:0] rtv);
    int unsigned gap;
    gap = tx_gaps_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, rtv, instr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    cop0_results_q.push_back(cop0_execute(instr, rtv));
  endtask

  task automatic random_cop0_item(output logic [25:0] instr, output logic [31:0] rtv);
    int unsigned pick;
    logic [15:0] tail;
    logic [31:0] st;
    logic [5:0]  fn;
    logic [4:0]  cond;
    pick = $urandom_range(0, 99);
    rtv  = $urandom;
    tail = ($urandom_range(0, 2) == 0) ? dbg_sel_of($urandom_range(0, 8)) : 16'($urandom);
    if (pick < 25) begin
      instr = {mc0_pkg::RS_MF, 5'($urandom), tail};
    end else if (pick < 50) begin
      instr = {mc0_pkg::RS_MT, 5'($urandom), tail};
    end else if (pick < 60) begin
      // status writes with the mode bits thinned so every ei / di outcome shows up
      st = $urandom;
      if ($urandom_range(0, 1)) st[mc0_pkg::ST_EXL] = 1'b0;
      if ($urandom_range(0, 1)) st[mc0_pkg::ST_ERL] = 1'b0;
      if ($urandom_range(0, 1)) st[mc0_pkg::ST_EDI] = 1'b0;
      if ($urandom_range(0, 1)) st[mc0_pkg::ST_KSU_HI:mc0_pkg::ST_KSU_LO] = 2'b00;
      rtv   = st;
      instr = {mc0_pkg::RS_MT, 5'($urandom), mc0_pkg::CP_STATUS, 11'($urandom)};
    end else if (pick < 75) begin
      case ($urandom_range(0, 7))
        0: fn = mc0_pkg::FN_TLBR;
        1: fn = mc0_pkg::FN_TLBWI;
        2: fn = mc0_pkg::FN_TLBWR;
        3: fn = mc0_pkg::FN_ERET;
        4: fn = mc0_pkg::FN_EI;
        5: fn = mc0_pkg::FN_DI;
        6: fn = FN_TLBP;
        default: fn = 6'($urandom);
      endcase
      instr = {mc0_pkg::RS_CO, 15'($urandom), fn};
    end else if (pick < 85) begin
      cond  = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      instr = {mc0_pkg::RS_BC, cond, 16'($urandom)};
    end else begin
      instr = 26'($urandom);
    end
  endtask

  task automatic test_directed_ops();
    send_instr(cop0_word(mc0_pkg::RS_MF, 5'd0, 5'd0, 11'h000), 32'h0);
    send_instr(cop0_word(mc0_pkg::RS_MT, 5'd31, 5'd31, 11'h7ff), 32'hffff_ffff);
    send_instr(cop0_word(mc0_pkg::RS_MF, 5'd31, 5'd31, 11'h7ff), 32'h0);
    // debug bank reached through the low-half selector
    send_instr({mc0_pkg::RS_MT, 5'd0, mc0_pkg::SEL_IAB}, 32'h8000_0000);
    send_instr({mc0_pkg::RS_MF, 5'd9, mc0_pkg::SEL_IAB}, 32'h0);
    // rd 25 without a selector pattern stays in the control file
    send_instr(cop0_word(mc0_pkg::RS_MF, 5'd2, 5'd25, 11'h005), 32'h0);
    send_instr(cop0_word(mc0_pkg::RS_MT, 5'd0, mc0_pkg::CP_EPC, 11'h0), 32'h1234_5678);
    send_instr(cop0_word(mc0_pkg::RS_MT, 5'd0, mc0_pkg::CP_ERROREPC, 11'h0),
               32'hbfc0_0380);
    // eret with erl set, then with only exl left
    send_instr(cop0_word(mc0_pkg::RS_MT, 5'd0, mc0_pkg::CP_STATUS, 11'h0),
               (32'd1 << mc0_pkg::ST_EXL) | (32'd1 << mc0_pkg::ST_ERL) |
               (32'd3 << mc0_pkg::ST_KSU_LO));
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_ERET}, 32'h0);
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_ERET}, 32'h0);
    // user mode with no flag: ei must be ignored
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_EI}, 32'h0);
    send_instr(cop0_word(mc0_pkg::RS_MT, 5'd0, mc0_pkg::CP_STATUS, 11'h0),
               (32'd1 << mc0_pkg::ST_EDI) | (32'd3 << mc0_pkg::ST_KSU_LO));
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_EI}, 32'h0);
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_DI}, 32'h0);
    send_instr(cop0_word(mc0_pkg::RS_MF, 5'd4, mc0_pkg::CP_STATUS, 11'h0), 32'h0);
    for (int c = 0; c < 4; c++)
      send_instr({mc0_pkg::RS_BC, 5'(c), 16'h0}, 32'h0);
    send_instr({mc0_pkg::RS_BC, 5'd31, 16'hffff}, 32'h0);
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_TLBR}, 32'h0);
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_TLBWI}, 32'h0);
    send_instr({mc0_pkg::RS_CO, 15'd0, mc0_pkg::FN_TLBWR}, 32'h0);
    send_instr({mc0_pkg::RS_CO, 15'd0, FN_TLBP}, 32'h0);
    send_instr({mc0_pkg::RS_CO, 15'h7fff, FN_BAD}, 32'h0);
    send_instr({RS_BAD, 21'h1f_ffff}, 32'hffff_ffff);
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_output_backpressure();
    logic [25:0] instr;
    logic [31:0] rtv;
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b0;
    rx_hold_len = 300;
    repeat (40) begin
      random_cop0_item(instr, rtv);
      send_instr(instr, rtv);
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_random_mix();
    logic [25:0] instr;
    logic [31:0] rtv;
    for (int i = 0; i < NumRandom; i++) begin
      // alternate stretches with and without idle cycles on each side
      tx_gaps_on = ((i / 250) % 2) == 0;
      rx_gaps_on = ((i / 150) % 3) != 2;
      random_cop0_item(instr, rtv);
      send_instr(instr, rtv);
    end
  endtask

  // receiver: per-result pause, plus the long hold-off when one is requested
  initial begin : rx_side
    int unsigned pause;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk_i);
        rx_hold_len = 0;
      end
      pause = rx_gaps_on ? $urandom_range(0, 16) : 0;
      if (pause != 0) begin
        m_axis_tready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // result fields from bit 0 up: gpr_write, gpr_index, gpr_value, pc_load,
  // new_pc, nullify_slot, invalid_op
  always @(posedge clk_i) begin : result_check
    mc0_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cop0_results_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", m_axis_tdata));
      end else begin
        want = cop0_results_q.pop_front();
        if (m_axis_tdata[0] !== want.gpr_write)
          report_mismatch($sformatf("gpr_write %h, want %h", m_axis_tdata[0], want.gpr_write));
        if (m_axis_tdata[5:1] !== want.gpr_index)
          report_mismatch($sformatf("gpr_index %h, want %h", m_axis_tdata[5:1],
                                    want.gpr_index));
        if (m_axis_tdata[37:6] !== want.gpr_value)
          report_mismatch($sformatf("gpr_value %h, want %h", m_axis_tdata[37:6],
                                    want.gpr_value));
        if (m_axis_tdata[38] !== want.pc_load)
          report_mismatch($sformatf("pc_load %h, want %h", m_axis_tdata[38], want.pc_load));
        if (m_axis_tdata[70:39] !== want.new_pc)
          report_mismatch($sformatf("new_pc %h, want %h", m_axis_tdata[70:39], want.new_pc));
        if (m_axis_tdata[71] !== want.nullify_slot)
          report_mismatch($sformatf("nullify_slot %h, want %h", m_axis_tdata[71],
                                    want.nullify_slot));
        if (m_axis_tdata[72] !== want.invalid_op)
          report_mismatch($sformatf("invalid_op %h, want %h", m_axis_tdata[72],
                                    want.invalid_op));
      end
    end
  end

  // ends a hung run: counts cycles with no transfer on either side
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
        $display("mips_cop0_system_control_top test failed");
        $finish;
      end
    end
  end

  initial begin : run
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_ops();
    test_output_backpressure();
    test_random_mix();
    s_axis_tvalid <= 1'b0;
    while (cop0_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mips_cop0_system_control_top test passed");
    end else begin
      $display("mips_cop0_system_control_top test failed");
    end
    $finish;
  end

endmodule

// File: mips_cop0_system_control_top.f
+incdir+hdl
hdl/mc0_pkg.sv
hdl/mips_cop0_system_control_top.sv
dv/tb_mips_cop0_system_control_top.sv
